>>> rtl/i2h_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2h_pkg: shared types and constants for the IEEE to IBM hex float converter
// Holds the status codes, the format widths, the stage record that crosses
// the middle pipeline register, and the subnormal normalizer.
// ----------------------------------------------------------------------------
package i2h_pkg;

    // Field widths of the IEEE binary64 input.
    localparam int IEEE_W      = 64;
    localparam int IEEE_EXP_W  = 11;
    localparam int IEEE_FRAC_W = 52;

    // Hex fraction width (14 hex digits) and single fraction width (6 digits).
    localparam int HFRAC_W     = 56;
    localparam int SFRAC_W     = 24;
    localparam int HEXP_W      = 11;
    localparam int LZ_W        = 6;

    // Base-16 exponent limits and excess-64 bias.
    localparam logic signed [HEXP_W-1:0] HEXP_MAX  = 11'sd63;
    localparam logic signed [HEXP_W-1:0] HEXP_MIN  = -11'sd64;
    localparam logic        [HEXP_W-1:0] HEXP_BIAS = 11'd64;

    // Digit counts of the two result formats.
    localparam logic [HEXP_W-1:0] DIGITS_SINGLE = 11'd6;
    localparam logic [HEXP_W-1:0] DIGITS_DOUBLE = 11'd14;

    localparam logic [IEEE_EXP_W-1:0] EXP_ALL_ONES = 11'h7FF;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_REPR = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // Normalizer output: fraction with its leading one at the top, and the
    // number of positions it was moved.
    typedef struct packed {
        logic [IEEE_FRAC_W-1:0] val;
        logic [LZ_W-1:0]        lz;
    } norm_t;

    // Item record held between the normalize stage and the round/pack stage.
    typedef struct packed {
        logic               neg;
        logic               dbl;
        logic               is_nan;
        logic               is_zero;
        logic [HEXP_W-1:0]  hexp;
        logic [HFRAC_W-1:0] frac;
    } mid_t;

    // Leading-zero shift of a nonzero subnormal fraction in six binary steps.
    function automatic norm_t normalize_frac(input logic [IEEE_FRAC_W-1:0] frac);
        norm_t r;
        r.val = frac;
        r.lz  = '0;
        if (r.val[51:20] == '0) begin
            r.val = r.val << 32;
            r.lz  = r.lz + 6'd32;
        end
        if (r.val[51:36] == '0) begin
            r.val = r.val << 16;
            r.lz  = r.lz + 6'd16;
        end
        if (r.val[51:44] == '0) begin
            r.val = r.val << 8;
            r.lz  = r.lz + 6'd8;
        end
        if (r.val[51:48] == '0) begin
            r.val = r.val << 4;
            r.lz  = r.lz + 6'd4;
        end
        if (r.val[51:50] == '0) begin
            r.val = r.val << 2;
            r.lz  = r.lz + 6'd2;
        end
        if (r.val[51] == 1'b0) begin
            r.val = r.val << 1;
            r.lz  = r.lz + 6'd1;
        end
        return r;
    endfunction

endpackage

>>> rtl/ieee_to_ibm_hex_float.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ieee_to_ibm_hex_float: IEEE binary64 to IBM hexadecimal float converter
// Converts one IEEE double per item into an IBM single (low 32 bits, rounded
// half to even) or an IBM double, with a status code for special cases.
//
// Usage:
//   The input channel (s_valid/s_ready) carries the IEEE bits and the format
//   flag; the result channel (m_valid/m_ready) carries the IBM bits and the
//   status. Each channel moves an item when valid and ready are both high.
//   The datapath has three register stages: input, normalize, round/pack.
//   Items pass the input, normalize and result registers in turn to m_valid.
//   Throughput is one item per cycle while m_ready is high; every stage
//   holds one item and moves it on whenever the stage after it is empty or
//   being emptied. When the receiver stalls, the result register holds its
//   item and the stages behind it fill; s_ready falls once all three are
//   full, and the upstream ready path runs combinationally from m_ready.
//   Synchronous active-low reset empties all stages; no item is in flight
//   afterwards and s_ready is high.
// ----------------------------------------------------------------------------
module ieee_to_ibm_hex_float
    import i2h_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [IEEE_W-1:0] s_ieee_bits,
    input  logic              s_double_format,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [IEEE_W-1:0] m_ibm_bits,
    output logic [1:0]        m_status
);

    // Stage registers.
    logic              in_valid_reg;
    logic [IEEE_W-1:0] in_bits_reg;
    logic              in_dbl_reg;
    logic              mid_valid_reg;
    mid_t              mid_reg;
    mid_t              mid_next;
    logic              out_valid_reg;
    logic [IEEE_W-1:0] out_bits_reg;
    logic [IEEE_W-1:0] out_bits_next;
    status_t           out_status_reg;
    status_t           out_status_next;
    logic              out_dbl_reg;

    // Stage advance enables.
    logic out_en;
    logic mid_en;
    logic in_en;

    assign out_en  = !out_valid_reg || m_ready;
    assign mid_en  = !mid_valid_reg || out_en;
    assign in_en   = !in_valid_reg || mid_en;
    assign s_ready = in_en;

    // ------------------------------------------------------------------
    // Normalize stage: decode, subnormal shift, hex alignment.
    // ------------------------------------------------------------------
    logic [IEEE_EXP_W-1:0]  efield;
    logic [IEEE_FRAC_W-1:0] ffield;
    norm_t                  norm;
    logic [IEEE_FRAC_W:0]   mant;
    logic signed [11:0]     x_s;
    logic [11:0]            neg_x;
    logic [1:0]             k;
    logic signed [11:0]     xk;
    logic signed [11:0]     h_full;

    always_comb begin
        efield = in_bits_reg[62:52];
        ffield = in_bits_reg[IEEE_FRAC_W-1:0];
        norm   = normalize_frac(ffield);

        // Value is 0.mant * 2^x with the leading bit of mant set.
        if (efield == '0) begin
            mant = {norm.val, 1'b0};
            x_s  = -12'sd1022 - $signed({6'b0, norm.lz});
        end else begin
            mant = {1'b1, ffield};
            x_s  = $signed({1'b0, efield}) - 12'sd1022;
        end

        // Round the binary exponent up to a multiple of four.
        neg_x  = 12'd0 - x_s;
        k      = neg_x[1:0];
        xk     = x_s + $signed({10'b0, k});
        h_full = xk >>> 2;

        mid_next.neg     = in_bits_reg[63];
        mid_next.dbl     = in_dbl_reg;
        mid_next.is_nan  = (efield == EXP_ALL_ONES);
        mid_next.is_zero = (efield == '0) && (ffield == '0);
        mid_next.hexp    = h_full[HEXP_W-1:0];
        mid_next.frac    = {3'b000, mant} << (2'd3 - k);
    end

    // ------------------------------------------------------------------
    // Round/pack stage: single rounding, overflow, underflow shift.
    // ------------------------------------------------------------------
    logic [SFRAC_W-1:0]       top;
    logic [31:0]              rest;
    logic                     rnd_incr;
    logic [SFRAC_W:0]         top_inc;
    logic                     carry;
    logic [SFRAC_W-1:0]       top_r;
    logic signed [HEXP_W-1:0] h_adj;
    logic [HFRAC_W-1:0]       frac_sel;
    logic [HEXP_W-1:0]        digits;
    logic                     ovf;
    logic                     under;
    logic [HEXP_W-1:0]        shift_digits;
    logic [HFRAC_W-1:0]       f_shift;
    logic [HFRAC_W-1:0]       f_fin;
    logic [HEXP_W-1:0]        h_p64;
    logic [6:0]               exp_field;

    always_comb begin
        // Round to 24 bits, half to even; a carry renormalizes by one digit.
        top      = mid_reg.frac[55:32];
        rest     = mid_reg.frac[31:0];
        rnd_incr = (rest > 32'h8000_0000) || ((rest == 32'h8000_0000) && top[0]);
        top_inc  = {1'b0, top} + 25'd1;
        carry    = rnd_incr && top_inc[SFRAC_W];
        if (carry) begin
            top_r = 24'h10_0000;
        end else if (rnd_incr) begin
            top_r = top_inc[SFRAC_W-1:0];
        end else begin
            top_r = top;
        end

        if (mid_reg.dbl) begin
            h_adj    = $signed(mid_reg.hexp);
            frac_sel = mid_reg.frac;
            digits   = DIGITS_DOUBLE;
        end else begin
            h_adj    = $signed(mid_reg.hexp) + $signed({10'b0, carry});
            frac_sel = {32'b0, top_r};
            digits   = DIGITS_SINGLE;
        end

        ovf          = h_adj > HEXP_MAX;
        under        = h_adj < HEXP_MIN;
        shift_digits = HEXP_MIN - h_adj;
        f_shift      = frac_sel >> {shift_digits[3:0], 2'b00};

        // Below the exponent floor: drop one hex digit per missing step.
        if (!under) begin
            f_fin = frac_sel;
        end else if (shift_digits >= digits) begin
            f_fin = '0;
        end else begin
            f_fin = f_shift;
        end

        h_p64     = h_adj + HEXP_BIAS;
        exp_field = (under || (f_fin == '0)) ? 7'd0 : h_p64[6:0];

        // Special cases first, then the packed result.
        out_status_next = ST_OK;
        priority if (mid_reg.is_nan) begin
            out_status_next = ST_NOT_REPR;
            out_bits_next   = '0;
        end else if (mid_reg.is_zero) begin
            out_bits_next = mid_reg.dbl ? {mid_reg.neg, 63'b0}
                                        : {32'b0, mid_reg.neg, 31'b0};
        end else if (ovf) begin
            out_status_next = ST_OVERFLOW;
            out_bits_next   = '0;
        end else if (mid_reg.dbl) begin
            out_bits_next = {mid_reg.neg, exp_field, f_fin};
        end else begin
            out_bits_next = {32'b0, mid_reg.neg, exp_field, f_fin[SFRAC_W-1:0]};
        end
    end

    // ------------------------------------------------------------------
    // Pipeline valid flags.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_en) begin
                in_valid_reg <= s_valid;
            end
            if (mid_en) begin
                mid_valid_reg <= in_valid_reg;
            end
            if (out_en) begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline payload registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (in_en && s_valid) begin
            in_bits_reg <= s_ieee_bits;
            in_dbl_reg  <= s_double_format;
        end
        if (mid_en && in_valid_reg) begin
            mid_reg <= mid_next;
        end
        if (out_en && mid_valid_reg) begin
            out_bits_reg   <= out_bits_next;
            out_status_reg <= out_status_next;
            out_dbl_reg    <= mid_reg.dbl;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_ibm_bits = out_bits_reg;
    assign m_status   = out_status_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A special-case status always comes with an all-zero result word.
    a_status_zero_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_status_reg != ST_OK)) |-> (out_bits_reg == '0))
        else $error("non-ok status with nonzero result bits");

    // Single-format results keep the upper word clear.
    a_single_upper_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_dbl_reg) |-> (out_bits_reg[63:32] == 32'b0))
        else $error("single result has upper word set");

    // An item leaving the input stage lands in the middle stage.
    a_in_to_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && mid_en) |=> mid_valid_reg)
        else $error("item lost between input and middle stage");

    // An item leaving the middle stage lands in the result register.
    a_mid_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (mid_valid_reg && out_en) |=> out_valid_reg)
        else $error("item lost between middle and result stage");

endmodule
